// ----- rtl/akrt_pkg.sv -----
// Shared types and constants for the analog key rapid trigger block.
`timescale 1ns / 1ps

package akrt_pkg;

    localparam int KEY_W       = 4;
    localparam int TRAVEL_W    = 12;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int KEY_CMP_W   = 9;

    localparam logic [CFG_W-1:0] ACT_LEVEL_RST   = 12'd500;
    localparam logic [CFG_W-1:0] SENSITIVITY_RST = 12'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACT_LEVEL   = 2'd0,
        CFG_SENSITIVITY = 2'd1
    } akrt_cfg_idx_t;

    typedef struct packed {
        logic             in_range;
        logic [KEY_W-1:0] key;
    } akrt_tag_t;

endpackage

// ----- rtl/analog_key_rapid_trigger_top.sv -----
// Top level of the analog key rapid trigger block.
//
// Each item on the s_ channel is one travel sample for one key. The block keeps,
// per key, the deepest and shallowest travel seen and a pressed flag, and returns
// one item on the m_ channel per input: the key, its pressed flag after the
// sample and a mark that the flag toggled. Keys at or above NUM_KEYS are passed
// through with pressed and changed low and leave no trace in the key state.
// Throughput is one item per cycle while the receiver takes results; an accepted
// input passes the queue, then the per-key state read-modify-write (RAM read and
// write-back forwarding), then the result register.
// The cfg channel writes the actuation level (index 0) and sensitivity (index 1);
// it is always ready. The user must write it only while no item is in flight;
// the block does not enforce this. After reset all keys are released with
// peaks at zero and full scale, the thresholds return to 500 and 100, and the
// queue is empty. When the receiver stalls, the result holds, the update stage
// holds behind it, and the two-entry input queue fills before s_ready drops.
`timescale 1ns / 1ps

module analog_key_rapid_trigger_top
    import akrt_pkg::*;
#(
    parameter int NUM_KEYS    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KEY_W-1:0]     s_key_number,
    input  logic [TRAVEL_W-1:0]  s_travel_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KEY_W-1:0]     m_key_echo,
    output logic                 m_pressed,
    output logic                 m_changed,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]       act_level_reg;
    logic [CFG_W-1:0]       sensitivity_reg;
    logic                   q_valid;
    logic                   q_ready;
    akrt_tag_t              q_tag;
    logic [SAMPLE_BITS-1:0] q_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_level_reg   <= ACT_LEVEL_RST;
            sensitivity_reg <= SENSITIVITY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (akrt_cfg_idx_t'(cfg_index))
                CFG_ACT_LEVEL:   act_level_reg   <= cfg_data;
                CFG_SENSITIVITY: sensitivity_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    akrt_front #(
        .NUM_KEYS    (NUM_KEYS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_number    (s_key_number),
        .s_travel_sample (s_travel_sample),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_tag           (q_tag),
        .q_sample        (q_sample)
    );

    akrt_back #(
        .NUM_KEYS    (NUM_KEYS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .act_level   (act_level_reg),
        .sensitivity (sensitivity_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_tag       (q_tag),
        .q_sample    (q_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_echo  (m_key_echo),
        .m_pressed   (m_pressed),
        .m_changed   (m_changed)
    );

endmodule

// ----- rtl/akrt_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module akrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/akrt_front.sv -----
// Input side: accept items, tag the key range and queue them for the update stage.
`timescale 1ns / 1ps

module akrt_front
    import akrt_pkg::*;
#(
    parameter int NUM_KEYS    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [KEY_W-1:0]       s_key_number,
    input  logic [TRAVEL_W-1:0]    s_travel_sample,
    output logic                   q_valid,
    input  logic                   q_ready,
    output akrt_tag_t              q_tag,
    output logic [SAMPLE_BITS-1:0] q_sample
);

    akrt_tag_t              tag_mem [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] smp_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QPTR_W:0]        count_reg;
    logic [QPTR_W:0]        count_next;
    logic                   push;
    logic                   pop;
    akrt_tag_t              in_tag;

    assign in_tag.key      = s_key_number;
    assign in_tag.in_range = (KEY_CMP_W'(s_key_number) < KEY_CMP_W'(NUM_KEYS));

    assign s_ready  = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = s_valid && s_ready;
    assign pop      = q_valid && q_ready;
    assign q_tag    = tag_mem[rd_ptr_reg];
    assign q_sample = smp_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            tag_mem[wr_ptr_reg] <= in_tag;
            smp_mem[wr_ptr_reg] <= SAMPLE_BITS'(s_travel_sample);
        end
    end

endmodule

// ----- rtl/akrt_back.sv -----
// Update side: per-key state read-modify-write and the result register.
`timescale 1ns / 1ps

module akrt_back
    import akrt_pkg::*;
#(
    parameter int NUM_KEYS    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CFG_W-1:0]       act_level,
    input  logic [CFG_W-1:0]       sensitivity,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  akrt_tag_t              q_tag,
    input  logic [SAMPLE_BITS-1:0] q_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KEY_W-1:0]       m_key_echo,
    output logic                   m_pressed,
    output logic                   m_changed
);

    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ST_W   = 2 * SAMPLE_BITS + 1;
    localparam int CW     = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 2;

    logic                   s2_valid_reg;
    akrt_tag_t              s2_tag_reg;
    logic [SAMPLE_BITS-1:0] s2_sample_reg;
    logic                   s2_adv;
    logic [KEY_AW-1:0]      s2_addr;

    logic                   fwd_valid_reg;
    logic [KEY_AW-1:0]      fwd_addr_reg;
    logic [ST_W-1:0]        fwd_data_reg;
    logic [NUM_KEYS-1:0]    entry_valid_reg;

    logic                   rd_en;
    logic [KEY_AW-1:0]      rd_addr;
    logic [ST_W-1:0]        rd_data;
    logic                   wr_en;
    logic [ST_W-1:0]        wr_data;

    logic [ST_W-1:0]        cur_state;
    logic [SAMPLE_BITS-1:0] cur_deep;
    logic [SAMPLE_BITS-1:0] cur_shallow;
    logic                   cur_down;
    logic [SAMPLE_BITS-1:0] dp1;
    logic [SAMPLE_BITS-1:0] sp1;
    logic [SAMPLE_BITS-1:0] new_deep;
    logic [SAMPLE_BITS-1:0] new_shallow;
    logic                   new_down;
    logic signed [CW-1:0]   s_v;
    logic signed [CW-1:0]   thr_v;
    logic signed [CW-1:0]   release_lvl;
    logic signed [CW-1:0]   press_lvl;

    logic                   m_valid_reg;
    logic [KEY_W-1:0]       m_key_echo_reg;
    logic                   m_pressed_reg;
    logic                   m_changed_reg;
    logic                   m_in_range_reg;

    assign s2_adv  = s2_valid_reg && (!m_valid_reg || m_ready);
    assign q_ready = !s2_valid_reg || s2_adv;
    assign rd_en   = q_valid && q_ready && q_tag.in_range;
    assign rd_addr = KEY_AW'(q_tag.key);
    assign s2_addr = KEY_AW'(s2_tag_reg.key);
    assign wr_en   = s2_adv && s2_tag_reg.in_range;
    assign wr_data = {new_down, new_shallow, new_deep};

    akrt_ram #(
        .WIDTH (ST_W),
        .DEPTH (NUM_KEYS),
        .AW    (KEY_AW)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s2_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s2_addr)) begin
            cur_state = fwd_data_reg;
        end else if (s2_tag_reg.in_range && entry_valid_reg[s2_addr]) begin
            cur_state = rd_data;
        end else begin
            cur_state = {1'b0, {SAMPLE_BITS{1'b1}}, {SAMPLE_BITS{1'b0}}};
        end
    end

    assign cur_down    = cur_state[ST_W-1];
    assign cur_shallow = cur_state[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign cur_deep    = cur_state[SAMPLE_BITS-1:0];

    assign dp1 = (s2_sample_reg > cur_deep) ? s2_sample_reg : cur_deep;
    assign sp1 = (s2_sample_reg < cur_shallow) ? s2_sample_reg : cur_shallow;

    assign s_v         = $signed(CW'(s2_sample_reg));
    assign thr_v       = $signed(CW'(act_level));
    assign release_lvl = $signed(CW'(dp1)) - $signed(CW'(sensitivity));
    assign press_lvl   = $signed(CW'(sp1)) + $signed(CW'(sensitivity));

    always_comb begin
        new_down    = cur_down;
        new_deep    = dp1;
        new_shallow = sp1;
        if (cur_down) begin
            if (s_v < release_lvl) begin
                new_down    = 1'b0;
                new_shallow = s2_sample_reg;
            end
        end else begin
            if ((s_v > thr_v) && (s_v > press_lvl)) begin
                new_down = 1'b1;
                new_deep = s2_sample_reg;
            end
            if (s_v < thr_v) begin
                new_down    = 1'b0;
                new_deep    = SAMPLE_BITS'(act_level);
                new_shallow = s2_sample_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (q_ready) begin
                s2_valid_reg <= q_valid;
            end
            if (wr_en) begin
                fwd_valid_reg            <= 1'b1;
                entry_valid_reg[s2_addr] <= 1'b1;
            end
            if (s2_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            s2_tag_reg    <= q_tag;
            s2_sample_reg <= q_sample;
        end
        if (wr_en) begin
            fwd_addr_reg <= s2_addr;
            fwd_data_reg <= wr_data;
        end
        if (s2_adv) begin
            m_key_echo_reg <= s2_tag_reg.key;
            m_in_range_reg <= s2_tag_reg.in_range;
            m_pressed_reg  <= s2_tag_reg.in_range && new_down;
            m_changed_reg  <= s2_tag_reg.in_range && (new_down != cur_down);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_key_echo = m_key_echo_reg;
    assign m_pressed  = m_pressed_reg;
    assign m_changed  = m_changed_reg;

    a_no_oob_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (s2_valid_reg && s2_tag_reg.in_range))
        else $error("state write for an out-of-range key");

    a_oob_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_in_range_reg) |-> (!m_pressed_reg && !m_changed_reg))
        else $error("out-of-range key reported as pressed or changed");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && m_valid_reg && !m_ready) |=> (s2_valid_reg && $stable(s2_tag_reg)))
        else $error("update stage moved while result stalled");

    a_fwd_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (fwd_valid_reg && entry_valid_reg[fwd_addr_reg]))
        else $error("written key not marked valid");

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the analog key rapid trigger block: random and directed travel samples, checked per key.
`timescale 1ns / 1ps

import akrt_pkg::*;

typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             pressed;
    logic             changed;
} key_report_t;

class key_state_tracker;
    int                  n_keys;
    logic [TRAVEL_W-1:0] deep_peak[];
    logic [TRAVEL_W-1:0] shallow_peak[];
    bit                  key_down[];
    logic [CFG_W-1:0]    act_level;
    logic [CFG_W-1:0]    sensitivity;
    key_report_t         pending_reports[$];
    int                  errors;

    function new(int num_keys);
        n_keys        = num_keys;
        deep_peak     = new[num_keys];
        shallow_peak  = new[num_keys];
        key_down      = new[num_keys];
        act_level     = ACT_LEVEL_RST;
        sensitivity   = SENSITIVITY_RST;
        errors        = 0;
        foreach (deep_peak[k]) begin
            deep_peak[k]    = '0;
            shallow_peak[k] = '1;
            key_down[k]     = 1'b0;
        end
    endfunction

    function void write_reg(akrt_cfg_idx_t idx, logic [CFG_W-1:0] val);
        if (idx == CFG_ACT_LEVEL) begin
            act_level = val;
        end else if (idx == CFG_SENSITIVITY) begin
            sensitivity = val;
        end
    endfunction

    function void note_sample(logic [KEY_W-1:0] key, logic [TRAVEL_W-1:0] smp);
        key_report_t rep;
        int          s;
        int          thr;
        int          sens;
        bit          was_down;
        rep.key     = key;
        rep.pressed = 1'b0;
        rep.changed = 1'b0;
        s           = int'(smp);
        thr         = int'(act_level);
        sens        = int'(sensitivity);
        if (int'(key) < n_keys) begin
            was_down = key_down[key];
            if (smp > deep_peak[key]) deep_peak[key] = smp;
            if (smp < shallow_peak[key]) shallow_peak[key] = smp;
            if (key_down[key]) begin
                if (s < int'(deep_peak[key]) - sens) begin
                    key_down[key]     = 1'b0;
                    shallow_peak[key] = smp;
                end
            end else begin
                if (s > thr && s > int'(shallow_peak[key]) + sens) begin
                    key_down[key]  = 1'b1;
                    deep_peak[key] = smp;
                end
                if (s < thr) begin
                    key_down[key]     = 1'b0;
                    deep_peak[key]    = act_level[TRAVEL_W-1:0];
                    shallow_peak[key] = smp;
                end
            end
            rep.pressed = key_down[key];
            rep.changed = (key_down[key] != was_down);
        end
        pending_reports.push_back(rep);
    endfunction

    function void check_report(logic [KEY_W-1:0] key, logic pressed, logic changed);
        key_report_t want;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual key %0d pressed %0b changed %0b",
                     $time, key, pressed, changed);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        if (key !== want.key) begin
            $display("%0t: key_echo expected %0d actual %0d", $time, want.key, key);
            errors++;
        end
        if (pressed !== want.pressed) begin
            $display("%0t: pressed (key %0d) expected %0b actual %0b",
                     $time, want.key, want.pressed, pressed);
            errors++;
        end
        if (changed !== want.changed) begin
            $display("%0t: changed (key %0d) expected %0b actual %0b",
                     $time, want.key, want.changed, changed);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_reports.size();
    endfunction
endclass

module tb_top;

    localparam int NUM_KEYS       = 16;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [KEY_W-1:0]     s_key_number    = '0;
    logic [TRAVEL_W-1:0]  s_travel_sample = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [KEY_W-1:0]     m_key_echo;
    logic                 m_pressed;
    logic                 m_changed;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = CFG_ACT_LEVEL;
    logic [CFG_W-1:0]     cfg_data        = '0;

    key_state_tracker tracker;

    int s_idle_pct  = 18;
    int m_idle_pct  = 52;
    int hold_seq    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int quiet_count = 0;
    int gen_thr     = 500;
    int gen_sens    = 100;
    int walk_pos[NUM_KEYS];
    int walk_dir[NUM_KEYS];

    analog_key_rapid_trigger_top #(
        .NUM_KEYS    (NUM_KEYS),
        .SAMPLE_BITS (TRAVEL_W)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_number    (s_key_number),
        .s_travel_sample (s_travel_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_echo      (m_key_echo),
        .m_pressed       (m_pressed),
        .m_changed       (m_changed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_ack != hold_seq) begin
            hold_ack  <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                tracker.write_reg(akrt_cfg_idx_t'(cfg_index), cfg_data);
            end
            if (m_valid && m_ready) begin
                tracker.check_report(m_key_echo, m_pressed, m_changed);
            end
            if (s_valid && s_ready) begin
                tracker.note_sample(s_key_number, s_travel_sample);
            end
            if ((cfg_valid && cfg_ready) || (m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_count);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    task automatic send_sample(input int key, input int smp);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_key_number    <= key[KEY_W-1:0];
        s_travel_sample <= smp[TRAVEL_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_thresholds(input int thr, input int sens);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ACT_LEVEL;
        cfg_data  <= thr[CFG_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_SENSITIVITY;
        cfg_data  <= sens[CFG_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        gen_thr  = thr;
        gen_sens = sens;
    endtask

    // walk each key up and down like a finger stroke, with some noise mixed in
    task automatic run_strokes(input int count);
        int key;
        int pick;
        int step;
        int smp;
        for (int n = 0; n < count; n++) begin
            key  = $urandom_range(NUM_KEYS - 1);
            pick = $urandom_range(99);
            if (pick < 12) begin
                smp = $urandom_range(4095);
            end else if (pick < 18) begin
                smp = gen_thr + int'($urandom_range(2)) - 1;
                if (smp < 0) smp = 0;
                if (smp > 4095) smp = 4095;
            end else begin
                step = $urandom_range(gen_sens + gen_sens / 2 + 8);
                if ($urandom_range(99) < 15) walk_dir[key] = -walk_dir[key];
                smp = walk_pos[key] + walk_dir[key] * step;
                if (smp >= 4095) begin
                    smp           = 4095;
                    walk_dir[key] = -1;
                end
                if (smp <= 0) begin
                    smp           = 0;
                    walk_dir[key] = 1;
                end
                walk_pos[key] = smp;
            end
            send_sample(key, smp);
        end
    endtask

    initial begin
        tracker = new(NUM_KEYS);
        foreach (walk_pos[k]) begin
            walk_pos[k] = $urandom_range(4095);
            walk_dir[k] = 1;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // forced off, press from full travel, hold, release one past sensitivity
        send_sample(0, 0);
        send_sample(0, 4095);
        send_sample(0, 4095);
        send_sample(0, 3995);
        send_sample(0, 3994);
        // sample equal to threshold, press just past sensitivity, release
        send_sample(1, 500);
        send_sample(1, 600);
        send_sample(1, 601);
        send_sample(1, 501);
        send_sample(1, 500);
        send_sample(1, 499);
        // full scale from reset cannot press; then full strokes
        send_sample(15, 4095);
        send_sample(15, 0);
        send_sample(15, 4095);
        send_sample(15, 0);
        send_sample(15, 0);
        send_sample(7, 2048);
        send_sample(8, 1);
        send_sample(3, 4094);
        send_sample(12, 1234);
        send_sample(5, 2730);
        send_sample(10, 1365);

        run_strokes(100);
        hold_seq <= hold_seq + 1;
        run_strokes(400);

        set_thresholds(0, 0);
        send_sample(2, 0);
        send_sample(2, 1);
        send_sample(2, 0);
        run_strokes(300);

        s_idle_pct = 52;
        m_idle_pct = 18;
        set_thresholds(4095, 4095);
        run_strokes(250);
        set_thresholds($urandom_range(4095), $urandom_range(400));
        run_strokes(300);

        s_idle_pct = 0;
        m_idle_pct = 0;
        set_thresholds(300, 20);
        run_strokes(300);
        set_thresholds(500, 100);
        run_strokes(300);

        drain();
        repeat (6) @(posedge aclk);
        if (tracker.outstanding() != 0) begin
            $display("%0t: results expected %0d actual 0", $time, tracker.outstanding());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
